// File: rtl/svpwm_pkg.sv
// Shared constants for the SVPWM min-max duty and compare unit.
package svpwm_pkg;

  localparam int CFS_W = 16;
  localparam logic [CFS_W-1:0] CFS_RESET = 16'd1000;
  localparam int CMP_W = 16;

  // Pipeline advance control handed to each divider lane.
  typedef struct packed {
    logic en;
  } pipe_ctrl_t;

endpackage

// File: rtl/svpwm_in_if.sv
// Input channel: one phase voltage triple and the bus voltage per beat.
interface svpwm_in_if #(
  parameter int VOLT_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [VOLT_BITS-1:0] phase_a_voltage;
  logic signed [VOLT_BITS-1:0] phase_b_voltage;
  logic signed [VOLT_BITS-1:0] phase_c_voltage;
  logic        [VOLT_BITS-1:0] supply_voltage;

  modport source (output valid, phase_a_voltage, phase_b_voltage, phase_c_voltage,
                  supply_voltage, input ready);
  modport sink   (input valid, phase_a_voltage, phase_b_voltage, phase_c_voltage,
                  supply_voltage, output ready);
endinterface

// File: rtl/svpwm_out_if.sv
// Output channel: three duties and three timer compare values per beat.
interface svpwm_out_if
  import svpwm_pkg::*;
#(
  parameter int DUTY_FRAC_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic                    valid_res;
  logic [DUTY_FRAC_BITS:0] duty_a;
  logic [DUTY_FRAC_BITS:0] duty_b;
  logic [DUTY_FRAC_BITS:0] duty_c;
  logic [CMP_W-1:0]        compare_a;
  logic [CMP_W-1:0]        compare_b;
  logic [CMP_W-1:0]        compare_c;

  modport source (output valid, valid_res, duty_a, duty_b, duty_c,
                  compare_a, compare_b, compare_c, input ready);
  modport sink   (input valid, valid_res, duty_a, duty_b, duty_c,
                  compare_a, compare_b, compare_c, output ready);
endinterface

// File: rtl/svpwm_cfg_if.sv
// Configuration write channel for the compare full-scale register.
interface svpwm_cfg_if
  import svpwm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CFS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/svpwm_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module svpwm_div
  import svpwm_pkg::*;
#(
  parameter int DVS_W = 18,
  parameter int Q_W   = 17
) (
  input  logic                   clk,
  input  pipe_ctrl_t             ctrl,
  input  logic [DVS_W+Q_W-1:0]   num,
  input  logic [DVS_W-1:0]       dvs,
  output logic [Q_W-1:0]         quo
);

  // Stage k holds partial remainder, remaining dividend bits and divisor.
  logic [DVS_W-1:0] rem   [Q_W];
  logic [Q_W-1:0]   low   [Q_W];
  logic [DVS_W-1:0] dvs_s [Q_W];
  logic [Q_W-1:0]   q     [Q_W+1];

  assign rem[0]   = num[DVS_W+Q_W-1:Q_W];
  assign low[0]   = num[Q_W-1:0];
  assign dvs_s[0] = dvs;
  assign q[0]     = '0;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           take;

    assign trial = {rem[k], low[k][Q_W-1]};
    assign diff  = trial - {1'b0, dvs_s[k]};
    assign take  = ~diff[DVS_W];

    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        q[k+1] <= {q[k][Q_W-2:0], take};
      end
    end

    if (k < Q_W-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctrl.en) begin
          rem[k+1]   <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
          low[k+1]   <= {low[k][Q_W-2:0], 1'b0};
          dvs_s[k+1] <= dvs_s[k];
        end
      end
    end
  end

  assign quo = q[Q_W];

endmodule

// File: rtl/svpwm_minmax_duty_compare_unit.sv
// Top level of the SVPWM min-max zero-sequence duty and compare unit.
//
// Usage:
//   cmd carries one beat per phase triple: three signed phase voltages and the
//   unsigned bus voltage in the same LSB. res returns one beat per cmd beat, in
//   order: valid_res, three Q1.DUTY_FRAC_BITS duties and three timer compares.
//   cfg writes compare_full_scale; write it only while the unit is empty.
// Throughput: one beat per cycle, sustained, while res is taken.
// Pipeline: DUTY_FRAC_BITS + 5 register stages (21 at default): three front
//   stages, the restoring divider with one quotient bit per stage, and the
//   compare multiply stage.
// Reset: rst clears all stage valid bits and loads compare_full_scale = 1000.
// Stall: when res is held off with a beat waiting, the whole pipeline holds
//   and cmd.ready drops; nothing is lost or repeated. A zero bus gives
//   valid_res = 0 with all duties and compares zero.
module svpwm_minmax_duty_compare_unit
  import svpwm_pkg::*;
#(
  parameter int VOLT_BITS      = 16,
  parameter int DUTY_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  svpwm_in_if.sink     cmd,
  svpwm_cfg_if.sink    cfg,
  svpwm_out_if.source  res
);

  localparam int V      = VOLT_BITS;
  localparam int FB     = DUTY_FRAC_BITS;
  localparam int DW     = V + 2;          // signed 2v - (max+min)
  localparam int MW     = V + 1;          // |d|, denominator
  localparam int DVS_W  = V + 2;          // 2 * den
  localparam int Q_W    = FB + 1;         // duty, 0..2^FB
  localparam int NUM_W  = DVS_W + Q_W;
  localparam int STAGES = Q_W + 4;
  localparam int S_DIV  = 3;              // first divider stage
  localparam int S_OUT  = STAGES - 1;
  localparam int PROD_W = Q_W + CFS_W;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] nz;
  logic              en;
  pipe_ctrl_t        ctrl;

  // Advance when the output slot is empty or being taken.
  assign en        = ~vld[S_OUT] | res.ready;
  assign ctrl.en   = en;
  assign cmd.ready = en;

  // Configuration register.
  logic [CFS_W-1:0] cfs;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfs <= CFS_RESET;
    end else if (cfg.valid) begin
      cfs <= cfg.data;
    end
  end

  // Valid and bus-nonzero flags travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], cmd.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nz <= {nz[STAGES-2:0], (cmd.supply_voltage != '0)};
    end
  end

  // Stage 1: max and min of the three phases.
  logic signed [V-1:0] hi, lo, hi_ab, lo_ab;
  logic signed [V-1:0] s1_va, s1_vb, s1_vc;
  logic signed [V:0]   s1_sum;
  logic        [V-1:0] s1_bus;

  always_comb begin
    hi_ab = (cmd.phase_a_voltage > cmd.phase_b_voltage) ?
            cmd.phase_a_voltage : cmd.phase_b_voltage;
    lo_ab = (cmd.phase_a_voltage < cmd.phase_b_voltage) ?
            cmd.phase_a_voltage : cmd.phase_b_voltage;
    hi    = (cmd.phase_c_voltage > hi_ab) ? cmd.phase_c_voltage : hi_ab;
    lo    = (cmd.phase_c_voltage < lo_ab) ? cmd.phase_c_voltage : lo_ab;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_va  <= cmd.phase_a_voltage;
      s1_vb  <= cmd.phase_b_voltage;
      s1_vc  <= cmd.phase_c_voltage;
      s1_sum <= (V+1)'(hi) + (V+1)'(lo);
      s1_bus <= cmd.supply_voltage;
    end
  end

  // Stage 2: twice the offset-free voltage and its magnitude.
  logic signed [DW-1:0] d_a, d_b, d_c;
  logic signed [DW-1:0] s2_da, s2_db, s2_dc;
  logic        [MW-1:0] s2_ma, s2_mb, s2_mc;
  logic        [V-1:0]  s2_bus;

  assign d_a = {s1_va[V-1], s1_va, 1'b0} - DW'(s1_sum);
  assign d_b = {s1_vb[V-1], s1_vb, 1'b0} - DW'(s1_sum);
  assign d_c = {s1_vc[V-1], s1_vc, 1'b0} - DW'(s1_sum);

  function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] x);
    logic [DW-1:0] a;
    a = x[DW-1] ? DW'(-x) : DW'(x);
    return a[MW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      s2_da  <= d_a;
      s2_db  <= d_b;
      s2_dc  <= d_c;
      s2_ma  <= mag(d_a);
      s2_mb  <= mag(d_b);
      s2_mc  <= mag(d_c);
      s2_bus <= s1_bus;
    end
  end

  // Stage 3: common denominator and divisor, and a dividend per phase.
  logic [MW-1:0]    m_ab, m_abc, den;
  logic [DVS_W-1:0] n_a, n_b, n_c;
  logic [NUM_W-1:0] s3_num_a, s3_num_b, s3_num_c;
  logic [DVS_W-1:0] s3_dvs;

  always_comb begin
    m_ab  = (s2_ma > s2_mb) ? s2_ma : s2_mb;
    m_abc = (s2_mc > m_ab) ? s2_mc : m_ab;
    den   = (m_abc > MW'(s2_bus)) ? m_abc : MW'(s2_bus);
    n_a   = DVS_W'(den) + DVS_W'(s2_da);
    n_b   = DVS_W'(den) + DVS_W'(s2_db);
    n_c   = DVS_W'(den) + DVS_W'(s2_dc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num_a <= {1'b0, n_a, {FB{1'b0}}} + NUM_W'(den);
      s3_num_b <= {1'b0, n_b, {FB{1'b0}}} + NUM_W'(den);
      s3_num_c <= {1'b0, n_c, {FB{1'b0}}} + NUM_W'(den);
      s3_dvs   <= {den, 1'b0};
    end
  end

  // Divider lanes, one per phase.
  logic [Q_W-1:0] q_a, q_b, q_c;

  svpwm_div #(.DVS_W(DVS_W), .Q_W(Q_W)) u_div_a (
    .clk(clk), .ctrl(ctrl), .num(s3_num_a), .dvs(s3_dvs), .quo(q_a));
  svpwm_div #(.DVS_W(DVS_W), .Q_W(Q_W)) u_div_b (
    .clk(clk), .ctrl(ctrl), .num(s3_num_b), .dvs(s3_dvs), .quo(q_b));
  svpwm_div #(.DVS_W(DVS_W), .Q_W(Q_W)) u_div_c (
    .clk(clk), .ctrl(ctrl), .num(s3_num_c), .dvs(s3_dvs), .quo(q_c));

  // Output stage: compare multiply, zero on an invalid bus.
  logic              nz_q;
  logic [Q_W-1:0]    duty_a, duty_b, duty_c;
  logic [PROD_W-1:0] prod_a, prod_b, prod_c;

  assign nz_q = nz[S_OUT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      duty_a <= nz_q ? q_a : '0;
      duty_b <= nz_q ? q_b : '0;
      duty_c <= nz_q ? q_c : '0;
      prod_a <= nz_q ? PROD_W'(q_a) * PROD_W'(cfs) : '0;
      prod_b <= nz_q ? PROD_W'(q_b) * PROD_W'(cfs) : '0;
      prod_c <= nz_q ? PROD_W'(q_c) * PROD_W'(cfs) : '0;
    end
  end

  assign res.valid     = vld[S_OUT];
  assign res.valid_res = nz[S_OUT];
  assign res.duty_a    = duty_a;
  assign res.duty_b    = duty_b;
  assign res.duty_c    = duty_c;
  assign res.compare_a = prod_a[FB +: CMP_W];
  assign res.compare_b = prod_b[FB +: CMP_W];
  assign res.compare_c = prod_c[FB +: CMP_W];

  // Divider stage index is only referenced here to tie the layout together.
  localparam int DIV_LAST = S_DIV + Q_W - 1;

  a_div_depth: assert property (@(posedge clk) DIV_LAST == S_OUT - 1)
    else $error("divider depth does not meet output stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[S_OUT] && !res.ready) |-> !cmd.ready)
    else $error("input taken while output stalled");

  a_zero_bus: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.valid_res) |->
      (res.duty_a == '0 && res.duty_b == '0 && res.duty_c == '0 &&
       res.compare_a == '0 && res.compare_b == '0 && res.compare_c == '0))
    else $error("nonzero result on invalid bus");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.duty_a <= (Q_W'(1) << FB) && res.duty_b <= (Q_W'(1) << FB) &&
                   res.duty_c <= (Q_W'(1) << FB)))
    else $error("duty above full scale");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the SVPWM min-max duty and compare unit.
module testbench
  import svpwm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = 16;
  localparam int FB = 16;
  localparam int LATENCY = FB + 5;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_BEATS = 650;

  typedef struct packed {
    logic          valid_res;
    logic [FB:0]   duty_a;
    logic [FB:0]   duty_b;
    logic [FB:0]   duty_c;
    logic [CMP_W-1:0] compare_a;
    logic [CMP_W-1:0] compare_b;
    logic [CMP_W-1:0] compare_c;
  } duty_beat_t;

  typedef struct packed {
    logic signed [VB-1:0] va;
    logic signed [VB-1:0] vb;
    logic signed [VB-1:0] vc;
    logic [VB-1:0]        bus;
    logic                 has_known; // expected value typed into the row
    duty_beat_t           known;
  } phase_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  svpwm_in_if  #(.VOLT_BITS(VB))     cmd ();
  svpwm_cfg_if                       cfg ();
  svpwm_out_if #(.DUTY_FRAC_BITS(FB)) res ();

  svpwm_minmax_duty_compare_unit #(.VOLT_BITS(VB), .DUTY_FRAC_BITS(FB)) u_top (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg), .res(res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: only the full-scale register.
  logic [CFS_W-1:0] full_scale_model;
  duty_beat_t       pending_duties[$];
  int               mismatches = 0;
  int               idle_cycles = 0;
  bit               long_hold = 1'b0;
  bit               stim_done = 1'b0;

  // Work out one duty beat from a phase triple and bus voltage.
  function automatic duty_beat_t predict_duties(logic signed [VB-1:0] va,
      logic signed [VB-1:0] vb, logic signed [VB-1:0] vc, logic [VB-1:0] bus);
    duty_beat_t r;
    longint v[3];
    longint d[3];
    longint hi, lo, mag, den, num, q;
    r = '0;
    if (bus == '0) return r;
    v[0] = va; v[1] = vb; v[2] = vc;
    hi = v[0]; lo = v[0];
    for (int i = 1; i < 3; i++) begin
      if (v[i] > hi) hi = v[i];
      if (v[i] < lo) lo = v[i];
    end
    mag = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 2 * v[i] - (hi + lo);
      if ((d[i] < 0 ? -d[i] : d[i]) > mag) mag = d[i] < 0 ? -d[i] : d[i];
    end
    den = (mag > longint'(bus)) ? mag : longint'(bus);
    r.valid_res = 1'b1;
    for (int i = 0; i < 3; i++) begin
      num = (den + d[i]) * (64'sd1 <<< FB) + den;
      q = num / (2 * den);
      if (q > (64'sd1 <<< FB)) q = 64'sd1 <<< FB;
      case (i)
        0: begin
          r.duty_a = q[FB:0];
          r.compare_a = CMP_W'((q * full_scale_model) >>> FB);
        end
        1: begin
          r.duty_b = q[FB:0];
          r.compare_b = CMP_W'((q * full_scale_model) >>> FB);
        end
        default: begin
          r.duty_c = q[FB:0];
          r.compare_c = CMP_W'((q * full_scale_model) >>> FB);
        end
      endcase
    end
    return r;
  endfunction

  // Gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // Offer one beat and hold it until the handshake completes.
  task automatic send_phase(logic signed [VB-1:0] va, logic signed [VB-1:0] vb,
      logic signed [VB-1:0] vc, logic [VB-1:0] bus);
    cmd.valid           <= 1'b1;
    cmd.phase_a_voltage <= va;
    cmd.phase_b_voltage <= vb;
    cmd.phase_c_voltage <= vc;
    cmd.supply_voltage  <= bus;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    pending_duties.push_back(predict_duties(va, vb, vc, bus));
  endtask

  task automatic drop_valid();
    cmd.valid <= 1'b0;
  endtask

  // Drain the pipeline, then write the register and mirror it in the model.
  task automatic write_full_scale(logic [CFS_W-1:0] value);
    while (pending_duties.size() != 0) @(posedge clk);
    wait_cycles(LATENCY + 2);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    full_scale_model = value;
  endtask

  // Send one beat with a random gap after it; valid stays up across a zero gap.
  task automatic send_with_gap(logic signed [VB-1:0] va, logic signed [VB-1:0] vb,
      logic signed [VB-1:0] vc, logic [VB-1:0] bus);
    int g;
    send_phase(va, vb, vc, bus);
    g = pick_gap();
    if (g != 0) begin
      drop_valid();
      wait_cycles(g);
    end
  endtask

  // Random phase triple: mostly realistic, some full-range noise.
  task automatic send_random_phase();
    logic signed [VB-1:0] va, vb, vc;
    logic [VB-1:0] bus;
    int shape;
    shape = $urandom_range(9);
    va = VB'($urandom); vb = VB'($urandom); vc = VB'($urandom); bus = VB'($urandom);
    if (shape < 6) begin
      // Balanced triple, a and b within -8192..8191; bus anywhere from 1 up.
      bus = VB'($urandom_range(1, 65535));
      va = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
      vb = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
      vc = -(va + vb);
    end else if (shape == 6) begin
      bus = VB'($urandom_range(1, 64));
    end else if (shape == 7) begin
      bus = (shape == 7 && $urandom_range(1)) ? 16'd0 : 16'($urandom_range(1, 3));
    end
    send_with_gap(va, vb, vc, bus);
  endtask

  // Directed table: extremes, zero bus, exact limit, scaling.
  phase_row_t directed[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1, '0},
    '{16'sd0, 16'sd0, 16'sd0, 16'd1, 1'b1,
      '{1'b1, 17'd32768, 17'd32768, 17'd32768, 16'd500, 16'd500, 16'd500}},
    '{-16'sd32768, 16'sd32767, 16'sd0, 16'd0, 1'b1, '0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'd65535, 1'b1,
      '{1'b1, 17'd32768, 17'd32768, 17'd32768, 16'd500, 16'd500, 16'd500}},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 16'd65535, 1'b1,
      '{1'b1, 17'd32768, 17'd32768, 17'd32768, 16'd500, 16'd500, 16'd500}},
    '{16'sd32767, -16'sd32768, 16'sd0, 16'd1, 1'b0, '0},
    '{16'sd32767, -16'sd32768, 16'sd0, 16'd65535, 1'b0, '0},
    '{-16'sd32768, 16'sd32767, 16'sd32767, 16'd65535, 1'b0, '0},
    '{16'sd100, -16'sd100, 16'sd0, 16'd200, 1'b0, '0},
    '{16'sd100, -16'sd100, 16'sd0, 16'd199, 1'b0, '0},
    '{16'sd100, -16'sd100, 16'sd0, 16'd201, 1'b0, '0},
    '{16'sd1, 16'sd0, -16'sd1, 16'd65535, 1'b0, '0},
    '{-16'sd1, -16'sd1, -16'sd1, 16'd65535, 1'b0, '0},
    '{16'sd12345, -16'sd5432, 16'sd777, 16'd30000, 1'b0, '0},
    '{-16'sd21846, 16'sd21845, 16'sd1, 16'd43690, 1'b0, '0}
  };

  // Stimulus and register phases.
  initial begin
    logic [CFS_W-1:0] scales[5];
    scales = '{16'd0, 16'd65535, 16'd1, 16'd1000, 16'd40000};
    full_scale_model = CFS_RESET;
    cmd.valid <= 1'b0;
    cmd.phase_a_voltage <= '0;
    cmd.phase_b_voltage <= '0;
    cmd.phase_c_voltage <= '0;
    cmd.supply_voltage  <= '0;
    cfg.valid <= 1'b0;
    cfg.data  <= '0;
    wait_cycles(2);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at the reset full scale; typed rows are checked verbatim.
    foreach (directed[i]) begin
      send_phase(directed[i].va, directed[i].vb, directed[i].vc, directed[i].bus);
      if (directed[i].has_known) pending_duties[$] = directed[i].known;
    end
    drop_valid();

    // Random phases spread over several full-scale settings.
    for (int s = 0; s < 5; s++) begin
      write_full_scale(scales[s]);
      for (int k = 0; k < RANDOM_BEATS / 5; k++) begin
        if (s == 2 && k == 20) long_hold = 1'b1;
        send_random_phase();
      end
      drop_valid();
    end
    while (pending_duties.size() != 0) @(posedge clk);
    wait_cycles(LATENCY + 4);
    stim_done = 1'b1;
  end

  // Result side: random back-pressure, with one long hold-off to fill the pipe.
  initial begin
    int g;
    res.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        res.ready <= 1'b0;
        wait_cycles(3 * LATENCY);
        long_hold = 1'b0;
      end
      g = pick_gap();
      if (g == 0) begin
        res.ready <= 1'b1;
        @(posedge clk);
      end else begin
        res.ready <= 1'b0;
        wait_cycles(g);
        res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    duty_beat_t got, want;
    if (!rst && res.valid && res.ready) begin
      got = '{res.valid_res, res.duty_a, res.duty_b, res.duty_c,
              res.compare_a, res.compare_b, res.compare_c};
      if (pending_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_duties.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat, and the final verdict.
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (stim_done) begin
      if (mismatches == 0 && pending_duties.size() == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
      $finish;
    end
  end

endmodule
